/* sv/i2c_srm_pkg.sv */
// Shared types and constants of the I2C slave register map.
`timescale 1ns / 1ps
package i2c_srm_pkg;

  localparam logic [2:0] KIND_RX_BYTE  = 3'd0;
  localparam logic [2:0] KIND_TX_REQ   = 3'd1;
  localparam logic [2:0] KIND_TX_ERR   = 3'd2;
  localparam logic [2:0] KIND_ADDR     = 3'd3;
  localparam logic [2:0] KIND_NOT_ADDR = 3'd4;
  localparam logic [2:0] KIND_HOST_RD  = 3'd5;
  localparam logic [2:0] KIND_HOST_WR  = 3'd6;

  localparam logic [1:0] PHASE_IDLE = 2'd0;
  localparam logic [1:0] PHASE_SEL  = 2'd1;
  localparam logic [1:0] PHASE_XFER = 2'd2;

  localparam logic [4:0] MAP_LENGTH_RESET = 5'd16;
  localparam logic [2:0] WORD_BYTES       = 3'd4;
  localparam logic [2:0] LAST_DIV_STEP    = 3'd7;

  typedef struct packed {
    logic [2:0]  kind;
    logic [7:0]  data_byte;
    logic        master_reading;
    logic [3:0]  host_index;
    logic [31:0] host_data;
  } in_item_t;

  typedef struct packed {
    logic        tx_valid;
    logic [7:0]  tx_byte;
    logic        word_written;
    logic [31:0] host_read_data;
    logic [1:0]  phase;
    logic        is_addressed;
    logic        flush_tx;
  } out_item_t;

  typedef struct packed {
    logic capture;
    logic mod_start;
    logic mem_rd;
    logic mem_wr;
    logic finish;
  } dp_cmd_t;

  typedef struct packed {
    logic [2:0] kind;
    logic       phase_idle;
    logic       tx_ok;
    logic       rx_last;
    logic       host_in_range;
    logic       mod_done;
    logic       out_free;
  } dp_status_t;

endpackage

/* sv/i2c_srm_chan_if.sv */
// Valid/ready channel carrying one payload item per transfer.
`timescale 1ns / 1ps
interface i2c_srm_chan_if #(parameter type T = logic) ();
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* sv/i2c_srm_mod_unit.sv */
// Restoring remainder unit, one dividend bit per cycle.
`timescale 1ns / 1ps
module i2c_srm_mod_unit
  import i2c_srm_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  input  logic [7:0] dividend,
  input  logic [4:0] divisor,
  output logic       done,
  output logic [4:0] remainder
);

  logic       busy;
  logic [2:0] step;
  logic [7:0] dvd;
  logic [4:0] rem;
  logic [5:0] trial;
  logic [4:0] rem_next;

  always_comb begin
    trial = {rem, dvd[7]};
    if (trial >= {1'b0, divisor}) begin
      rem_next = 5'(trial - {1'b0, divisor});
    end else begin
      rem_next = trial[4:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        step <= step + 3'd1;
        if (step == LAST_DIV_STEP) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      dvd <= dividend;
    end else if (busy) begin
      rem <= rem_next;
      dvd <= {dvd[6:0], 1'b0};
    end
  end

  assign remainder = rem;

endmodule

/* sv/i2c_srm_regfile.sv */
// Register file memory with per-entry valid bits so unwritten entries read zero.
`timescale 1ns / 1ps
module i2c_srm_regfile #(
  parameter int MAP_DEPTH = 16,
  parameter int IW        = 4
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          wr_en,
  input  logic [IW-1:0] wr_addr,
  input  logic [31:0]   wr_data,
  input  logic          rd_en,
  input  logic [IW-1:0] rd_addr,
  output logic [31:0]   rd_data
);

  logic [31:0]          mem [MAP_DEPTH];
  logic [MAP_DEPTH-1:0] valid;
  logic [31:0]          rd_word;
  logic                 rd_hit;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_word <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid  <= '0;
      rd_hit <= 1'b0;
    end else begin
      if (wr_en) begin
        valid[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_hit <= valid[rd_addr];
      end
    end
  end

  assign rd_data = rd_hit ? rd_word : '0;

endmodule

/* sv/i2c_srm_datapath.sv */
// Datapath: transaction state, map length register, register file and result register.
`timescale 1ns / 1ps
module i2c_srm_datapath
  import i2c_srm_pkg::*;
#(
  parameter int MAP_DEPTH = 16
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_wr_en,
  input  logic [4:0] cfg_wr_data,
  input  in_item_t   in_item,
  input  dp_cmd_t    cmd,
  output dp_status_t status,
  output logic       out_valid,
  output out_item_t  out_item,
  input  logic       out_ready
);

  localparam int         IW     = (MAP_DEPTH > 1) ? $clog2(MAP_DEPTH) : 1;
  localparam logic [8:0] DEPTH9 = 9'(MAP_DEPTH);

  in_item_t    item;
  logic [4:0]  map_length;
  logic [1:0]  phase_reg;
  logic [7:0]  selected_index;
  logic [2:0]  byte_count;
  logic [31:0] assembled_word;
  logic        addressed_flag;

  logic [1:0]  phase_next;
  logic [7:0]  selected_index_next;
  logic [2:0]  byte_count_next;
  logic [31:0] assembled_word_next;
  logic        addressed_flag_next;
  out_item_t   result_next;

  logic [8:0]  len9;
  logic [4:0]  eff_len;
  logic        mod_done;
  logic [4:0]  entry;
  logic [8:0]  entry9;
  logic [8:0]  host9;
  logic [2:0]  count_inc;
  logic [4:0]  shift;
  logic [31:0] word_merged;
  logic        use_entry;
  logic [IW-1:0] mem_addr;
  logic [31:0] mem_wr_data;
  logic [31:0] rd_data;

  always_comb begin
    if (map_length == 5'd0) begin
      len9 = 9'd1;
    end else begin
      len9 = {4'd0, map_length};
    end
    if (len9 > DEPTH9) begin
      len9 = DEPTH9;
    end
    eff_len = len9[4:0];
  end

  i2c_srm_mod_unit u_mod (
    .clk       (clk),
    .rst       (rst),
    .start     (cmd.mod_start),
    .dividend  (selected_index),
    .divisor   (eff_len),
    .done      (mod_done),
    .remainder (entry)
  );

  assign entry9      = {4'd0, entry};
  assign host9       = {5'd0, item.host_index};
  assign count_inc   = byte_count + 3'd1;
  assign shift       = {byte_count[1:0], 3'b000};
  assign word_merged = assembled_word | (32'(item.data_byte) << shift);
  assign use_entry   = (item.kind == KIND_RX_BYTE) || (item.kind == KIND_TX_REQ);
  assign mem_addr    = use_entry ? entry9[IW-1:0] : host9[IW-1:0];
  assign mem_wr_data = use_entry ? word_merged : item.host_data;

  i2c_srm_regfile #(
    .MAP_DEPTH (MAP_DEPTH),
    .IW        (IW)
  ) u_regfile (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (cmd.mem_wr),
    .wr_addr (mem_addr),
    .wr_data (mem_wr_data),
    .rd_en   (cmd.mem_rd),
    .rd_addr (mem_addr),
    .rd_data (rd_data)
  );

  assign status.kind          = item.kind;
  assign status.phase_idle    = (phase_reg == PHASE_IDLE);
  assign status.tx_ok         = ((phase_reg == PHASE_SEL) || (phase_reg == PHASE_XFER))
                                && item.master_reading;
  assign status.rx_last       = (count_inc == WORD_BYTES);
  assign status.host_in_range = (host9 < DEPTH9);
  assign status.mod_done      = mod_done;
  assign status.out_free      = !out_valid || out_ready;

  always_comb begin
    phase_next          = phase_reg;
    selected_index_next = selected_index;
    byte_count_next     = byte_count;
    assembled_word_next = assembled_word;
    addressed_flag_next = addressed_flag;
    result_next         = '0;
    case (item.kind)
      KIND_RX_BYTE: begin
        if (phase_reg == PHASE_IDLE) begin
          byte_count_next     = '0;
          assembled_word_next = '0;
          selected_index_next = item.data_byte;
          phase_next          = PHASE_SEL;
        end else begin
          assembled_word_next = word_merged;
          byte_count_next     = count_inc;
          if (count_inc == WORD_BYTES) begin
            phase_next               = PHASE_IDLE;
            result_next.word_written = 1'b1;
          end else begin
            phase_next = PHASE_XFER;
          end
        end
      end
      KIND_TX_REQ: begin
        if (status.tx_ok) begin
          result_next.tx_valid = 1'b1;
          result_next.tx_byte  = 8'(rd_data >> shift);
          byte_count_next      = {1'b0, count_inc[1:0]};
          phase_next           = (count_inc == WORD_BYTES) ? PHASE_IDLE : PHASE_XFER;
        end
      end
      KIND_TX_ERR: begin
        phase_next           = PHASE_IDLE;
        result_next.flush_tx = 1'b1;
      end
      KIND_ADDR: begin
        addressed_flag_next = 1'b1;
      end
      KIND_NOT_ADDR: begin
        addressed_flag_next = 1'b0;
      end
      KIND_HOST_RD: begin
        if (status.host_in_range) begin
          result_next.host_read_data = rd_data;
        end
      end
      default: begin
      end
    endcase
    result_next.phase        = phase_next;
    result_next.is_addressed = addressed_flag_next;
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      item <= in_item;
    end
    if (cmd.finish) begin
      out_item <= result_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      map_length     <= MAP_LENGTH_RESET;
      phase_reg      <= PHASE_IDLE;
      selected_index <= '0;
      byte_count     <= '0;
      assembled_word <= '0;
      addressed_flag <= 1'b0;
      out_valid      <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        map_length <= cfg_wr_data;
      end
      if (cmd.finish) begin
        phase_reg      <= phase_next;
        selected_index <= selected_index_next;
        byte_count     <= byte_count_next;
        assembled_word <= assembled_word_next;
        addressed_flag <= addressed_flag_next;
        out_valid      <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

/* sv/i2c_srm_ctrl.sv */
// Controller state machine sequencing decode, remainder, memory access and result.
`timescale 1ns / 1ps
module i2c_srm_ctrl
  import i2c_srm_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  dp_status_t status,
  output dp_cmd_t    cmd
);

  typedef enum logic [6:0] {
    S_IDLE     = 7'b0000001,
    S_DECODE   = 7'b0000010,
    S_MOD_GO   = 7'b0000100,
    S_MOD_WAIT = 7'b0001000,
    S_MEM      = 7'b0010000,
    S_MEM_WAIT = 7'b0100000,
    S_FINISH   = 7'b1000000
  } state_t;

  state_t state;
  state_t state_next;

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = in_valid;
        if (in_valid) begin
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        case (status.kind)
          KIND_RX_BYTE: begin
            state_next = (!status.phase_idle && status.rx_last) ? S_MOD_GO : S_FINISH;
          end
          KIND_TX_REQ: begin
            state_next = status.tx_ok ? S_MOD_GO : S_FINISH;
          end
          KIND_HOST_RD, KIND_HOST_WR: begin
            state_next = status.host_in_range ? S_MEM : S_FINISH;
          end
          default: begin
            state_next = S_FINISH;
          end
        endcase
      end
      S_MOD_GO: begin
        cmd.mod_start = 1'b1;
        state_next    = S_MOD_WAIT;
      end
      S_MOD_WAIT: begin
        if (status.mod_done) begin
          state_next = S_MEM;
        end
      end
      S_MEM: begin
        if ((status.kind == KIND_TX_REQ) || (status.kind == KIND_HOST_RD)) begin
          cmd.mem_rd = 1'b1;
        end else begin
          cmd.mem_wr = 1'b1;
        end
        state_next = S_MEM_WAIT;
      end
      S_MEM_WAIT: begin
        state_next = S_FINISH;
      end
      S_FINISH: begin
        if (status.out_free) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

/* sv/i2c_slave_register_map.sv */
// Top level of the I2C slave register map: byte events in, one result per event out.
//
//   Channel    Direction  Payload
//   request    in         kind, data_byte, master_reading, host_index, host_data
//   response   out        tx_valid, tx_byte, word_written, host_read_data, phase,
//                         is_addressed, flush_tx
//   cfg        in         map_length (write enable and data, no read-back)
//
// An event with no register file access passes the decode and finish states; a host read
// or write also passes the memory and memory-wait states, and a word store or a byte
// transmit first waits for the 8-step remainder unit to find the entry before the memory
// port. One event is in work at a time; a result waits in the output register while the
// next event is taken. Synchronous reset clears the state and the valid bits of all entries.
`timescale 1ns / 1ps
module i2c_slave_register_map
  import i2c_srm_pkg::*;
#(
  parameter int MAP_DEPTH = 16
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_wr_en,
  input  logic [4:0] cfg_wr_data,
  i2c_srm_chan_if.sink   request,
  i2c_srm_chan_if.source response
);

  dp_cmd_t    cmd;
  dp_status_t status;
  logic       in_ready;

  i2c_srm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (request.valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  i2c_srm_datapath #(
    .MAP_DEPTH (MAP_DEPTH)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_item     (request.data),
    .cmd         (cmd),
    .status      (status),
    .out_valid   (response.valid),
    .out_item    (response.data),
    .out_ready   (response.ready)
  );

  assign request.ready = in_ready;

endmodule
